@@ rtl/scfp_pkg.sv @@
package scfp_pkg;

   localparam logic [7:0]  START_MARK    = 8'hAA;
   localparam logic [7:0]  CHAR_CR       = 8'h0D;
   localparam logic [7:0]  CHAR_LF       = 8'h0A;
   localparam logic [7:0]  CHAR_BS       = 8'h08;
   localparam logic [7:0]  CHAR_DEL      = 8'h7F;
   localparam logic [7:0]  CHAR_LOW      = 8'h20;
   localparam logic [7:0]  CHAR_HIGH     = 8'h7E;
   localparam logic [7:0]  MIN_FRAME     = 8'd4;
   localparam logic [7:0]  FIRST_OP_IDX  = 8'd2;
   localparam logic [7:0]  MAX_OPCODE    = 8'd5;
   localparam logic [15:0] TIMEOUT_RESET = 16'd250;
   localparam logic [15:0] IDLE_MAX      = 16'hFFFF;
   localparam int          QUEUE_DEPTH   = 2;

   localparam logic [2:0] KIND_COMMAND  = 3'd0;
   localparam logic [2:0] KIND_BAD_LEN  = 3'd1;
   localparam logic [2:0] KIND_BAD_SUM  = 3'd2;
   localparam logic [2:0] KIND_BAD_OP   = 3'd3;
   localparam logic [2:0] KIND_TIMEOUT  = 3'd4;
   localparam logic [2:0] KIND_TOO_LONG = 3'd5;
   localparam logic [2:0] KIND_LINE     = 3'd6;

   typedef struct packed {
      logic       mode;
      logic [7:0] rx_byte;
   } req_word_type;

   typedef struct packed {
      logic [2:0] event_kind;
      logic [2:0] command_code;
      logic [6:0] line_length;
      logic       last_of_run;
   } rsp_word_type;

   // one queued job: a single event, or a walk over a checked frame
   typedef struct packed {
      logic       walk;
      logic [2:0] kind;
      logic [6:0] line_length;
      logic [7:0] frame_length;
   } job_type;

   typedef struct packed {
      logic walk_done;
   } back_status_type;

endpackage

@@ rtl/scfp_ram.sv @@
module scfp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/scfp_queue.sv @@
module scfp_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  scfp_pkg::job_type push_job,
   output logic              full,
   output logic              pop_valid,
   output scfp_pkg::job_type pop_job,
   input  logic              pop
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   scfp_pkg::job_type job_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_job   = job_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         job_ff[wr_ptr_ff] <= push_job;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/scfp_front.sv @@
module scfp_front #(
   parameter int FRAME_BYTES = 32,
   parameter int LINE_BYTES  = 128
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  scfp_pkg::req_word_type         req_word,
   input  logic                           csr_valid,
   input  logic [15:0]                    csr_data,
   output logic                           push,
   output scfp_pkg::job_type              push_job,
   input  logic                           queue_full,
   input  scfp_pkg::back_status_type      back_status,
   output logic                           ram_we,
   output logic [$clog2(FRAME_BYTES)-1:0] ram_waddr,
   output logic [7:0]                     ram_wdata
);

   localparam int AW = $clog2(FRAME_BYTES);
   localparam int CW = $clog2(FRAME_BYTES + 1);
   localparam int TW = (LINE_BYTES > 2) ? $clog2(LINE_BYTES) : 1;

   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    length_ff, length_in;
   logic [7:0]    sum_ff, sum_in;
   logic [15:0]   idle_ff, idle_in;
   logic [TW-1:0] text_ff, text_in;
   logic          hold_ff, hold_in;
   logic [15:0]   timeout_ff;

   logic          accept;
   logic          frame_open;
   logic [15:0]   idle_inc;
   logic [CW-1:0] count_next;
   logic [TW:0]   text_plus;
   logic [TW+6:0] text_wide;
   logic [7:0]    b;

   assign b          = req_word.rx_byte;
   assign req_ready  = !queue_full && !hold_ff;
   assign accept     = req_valid && req_ready;
   assign frame_open = (count_ff != '0) || (b == scfp_pkg::START_MARK && text_ff == '0);
   assign idle_inc   = (idle_ff == scfp_pkg::IDLE_MAX) ? idle_ff : idle_ff + 16'd1;
   assign count_next = count_ff + CW'(1);
   assign text_plus  = {1'b0, text_ff} + (TW+1)'(1);
   assign text_wide  = (TW+7)'(text_ff);
   assign ram_waddr  = count_ff[AW-1:0];
   assign ram_wdata  = b;

   always_comb begin
      count_in  = count_ff;
      length_in = length_ff;
      sum_in    = sum_ff;
      idle_in   = idle_ff;
      text_in   = text_ff;
      hold_in   = hold_ff;
      push      = 1'b0;
      push_job  = '0;
      ram_we    = 1'b0;
      if (back_status.walk_done) begin
         hold_in = 1'b0;
      end
      if (accept) begin
         if (req_word.mode) begin
            if (count_ff != '0) begin
               idle_in = idle_inc;
               if (idle_inc > timeout_ff) begin
                  count_in      = '0;
                  length_in     = '0;
                  push          = 1'b1;
                  push_job.kind = scfp_pkg::KIND_TIMEOUT;
               end
            end
         end else if (frame_open) begin
            idle_in = '0;
            ram_we  = (count_ff < CW'(FRAME_BYTES));
            if (count_ff == '0) begin
               count_in  = CW'(1);
               length_in = '0;
               sum_in    = b;
            end else if (count_ff == CW'(1)) begin
               length_in = b;
               sum_in    = sum_ff + b;
               if (b < scfp_pkg::MIN_FRAME || {1'b0, b} > 9'(FRAME_BYTES)) begin
                  count_in      = '0;
                  length_in     = '0;
                  push          = 1'b1;
                  push_job.kind = scfp_pkg::KIND_BAD_LEN;
               end else begin
                  count_in = CW'(2);
               end
            end else if (9'(count_next) >= {1'b0, length_ff}) begin
               // b is the check byte, sum_ff covers every earlier byte
               count_in  = '0;
               length_in = '0;
               push      = 1'b1;
               if (b != 8'd0 && b != sum_ff) begin
                  push_job.kind = scfp_pkg::KIND_BAD_SUM;
               end else begin
                  push_job.walk         = 1'b1;
                  push_job.frame_length = length_ff;
                  hold_in               = 1'b1;
               end
            end else begin
               count_in = count_next;
               sum_in   = sum_ff + b;
            end
         end else if (b == scfp_pkg::CHAR_CR || b == scfp_pkg::CHAR_LF) begin
            if (text_ff != '0) begin
               push                 = 1'b1;
               push_job.kind        = scfp_pkg::KIND_LINE;
               push_job.line_length = text_wide[6:0];
               text_in              = '0;
            end
         end else if (b == scfp_pkg::CHAR_BS || b == scfp_pkg::CHAR_DEL) begin
            if (text_ff != '0) begin
               text_in = text_ff - TW'(1);
            end
         end else if (b >= scfp_pkg::CHAR_LOW && b <= scfp_pkg::CHAR_HIGH) begin
            if (text_plus >= (TW+1)'(LINE_BYTES)) begin
               text_in       = '0;
               push          = 1'b1;
               push_job.kind = scfp_pkg::KIND_TOO_LONG;
            end else begin
               text_in = text_plus[TW-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         length_ff  <= '0;
         sum_ff     <= '0;
         idle_ff    <= '0;
         text_ff    <= '0;
         hold_ff    <= 1'b0;
         timeout_ff <= scfp_pkg::TIMEOUT_RESET;
      end else begin
         count_ff  <= count_in;
         length_ff <= length_in;
         sum_ff    <= sum_in;
         idle_ff   <= idle_in;
         text_ff   <= text_in;
         hold_ff   <= hold_in;
         if (csr_valid) begin
            timeout_ff <= csr_data;
         end
      end
   end

endmodule

@@ rtl/scfp_back.sv @@
module scfp_back #(
   parameter int FRAME_BYTES = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           job_valid,
   input  scfp_pkg::job_type              job,
   output logic                           job_pop,
   output logic [$clog2(FRAME_BYTES)-1:0] ram_raddr,
   input  logic [7:0]                     ram_rdata,
   output scfp_pkg::back_status_type      back_status,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output scfp_pkg::rsp_word_type         rsp_word
);

   localparam int AW = $clog2(FRAME_BYTES);

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   state_type              state_ff, state_in;
   logic [7:0]             idx_ff, idx_in;
   logic [7:0]             end_ff, end_in;
   scfp_pkg::rsp_word_type rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;
   // read address follows next index so data lines up with idx_ff
   assign ram_raddr = idx_in[AW-1:0];

   always_comb begin
      state_in              = state_ff;
      idx_in                = idx_ff;
      end_in                = end_ff;
      rsp_in                = rsp_ff;
      rsp_valid_in          = rsp_valid_ff && !rsp_ready;
      job_pop               = 1'b0;
      back_status.walk_done = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid && out_free) begin
               job_pop = 1'b1;
               if (job.walk) begin
                  idx_in   = scfp_pkg::FIRST_OP_IDX;
                  end_in   = job.frame_length - 8'd2;
                  state_in = ST_WALK;
               end else begin
                  rsp_valid_in        = 1'b1;
                  rsp_in.event_kind   = job.kind;
                  rsp_in.command_code = 3'd0;
                  rsp_in.line_length  = job.line_length;
                  rsp_in.last_of_run  = 1'b1;
               end
            end
         end
         ST_WALK: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.line_length = 7'd0;
               rsp_in.last_of_run = (idx_ff == end_ff);
               if (ram_rdata <= scfp_pkg::MAX_OPCODE) begin
                  rsp_in.event_kind   = scfp_pkg::KIND_COMMAND;
                  rsp_in.command_code = ram_rdata[2:0];
               end else begin
                  rsp_in.event_kind   = scfp_pkg::KIND_BAD_OP;
                  rsp_in.command_code = 3'd0;
               end
               if (idx_ff == end_ff) begin
                  state_in              = ST_IDLE;
                  back_status.walk_done = 1'b1;
               end else begin
                  idx_in = idx_ff + 8'd1;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      end_ff <= end_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/serial_command_frame_parser.sv @@
// A single result is queued as its word is taken, then registered on rsp once popped.
// A completed frame is queued at its check byte, then its walk shows one result per cycle
// while rsp is not stalled; req stalls until the frame store walk ends (length - 3 results).
// Throughput: one word per cycle outside that walk while the job queue is not full.
// Reset: synchronous, active high; clears control state, the frame store is not cleared.
module serial_command_frame_parser #(
   parameter int FRAME_BYTES = 32,
   parameter int LINE_BYTES  = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  scfp_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output scfp_pkg::rsp_word_type rsp_word,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [15:0]            csr_data
);

   localparam int AW = $clog2(FRAME_BYTES);

   logic                      q_push;
   scfp_pkg::job_type         q_push_job;
   logic                      q_full;
   logic                      q_valid;
   scfp_pkg::job_type         q_job;
   logic                      q_pop;
   scfp_pkg::back_status_type back_status;
   logic                      ram_we;
   logic [AW-1:0]             ram_waddr;
   logic [7:0]                ram_wdata;
   logic [AW-1:0]             ram_raddr;
   logic [7:0]                ram_rdata;

   assign csr_ready = 1'b1;

   scfp_front #(
      .FRAME_BYTES(FRAME_BYTES),
      .LINE_BYTES (LINE_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .push       (q_push),
      .push_job   (q_push_job),
      .queue_full (q_full),
      .back_status(back_status),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata)
   );

   scfp_queue #(
      .DEPTH(scfp_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_push_job),
      .full     (q_full),
      .pop_valid(q_valid),
      .pop_job  (q_job),
      .pop      (q_pop)
   );

   scfp_ram #(
      .WIDTH(8),
      .DEPTH(FRAME_BYTES)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   scfp_back #(
      .FRAME_BYTES(FRAME_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (q_valid),
      .job        (q_job),
      .job_pop    (q_pop),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata),
      .back_status(back_status),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word)
   );

endmodule

@@ rtl/scfp_checker.sv @@
module scfp_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input scfp_pkg::rsp_word_type rsp_word
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("rsp word changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.event_kind <= scfp_pkg::KIND_LINE)
      else $error("undefined event kind");

   a_code_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.event_kind != scfp_pkg::KIND_COMMAND
         |-> rsp_word.command_code == 3'd0)
      else $error("command code on non-command event");

   a_len_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.event_kind != scfp_pkg::KIND_LINE
         |-> rsp_word.line_length == 7'd0)
      else $error("line length on non-line event");

endmodule

bind serial_command_frame_parser scfp_checker u_checker (.*);
